/* rtl/decimal_string_to_int32_macros.svh */
// Assertion macros used by the decimal string converter parser.
`ifndef DECIMAL_STRING_TO_INT32_MACROS_SVH
`define DECIMAL_STRING_TO_INT32_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define DSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsi: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define DSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsi: next-cycle check failed");

`endif

/* rtl/dsi_pkg.sv */
// Types, byte codes and helpers for the decimal string converter.
package dsi_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_TAIL  = 2'd3
  } phase_e;

  // Byte codes
  localparam logic [7:0] CH_TERM  = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Accumulator widths and limits (magnitude * 10 + 9 fits in 36 bits)
  localparam int unsigned MagW = 32;
  localparam int unsigned AccW = 36;
  localparam logic [AccW-1:0] POS_LIMIT = 36'd2147483647;
  localparam logic [AccW-1:0] NEG_LIMIT = 36'd2147483648;

  // One result item
  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/dsi_in_reg.sv */
// Input register: holds one byte item until the parser takes it.
module dsi_in_reg
  import dsi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       valid_o,
  output logic [7:0] ch_o,
  input  logic       take_i
);

  logic       valid_q;
  logic [7:0] ch_q;
  logic       load;

  // Free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q <= ch_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;

endmodule

/* rtl/dsi_parser.sv */
// Per-byte parse step: phase, sign, magnitude and sticky error state.
module dsi_parser
  import dsi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] ch_i,
  output logic       take_o,
  input  logic       slot_free_i,
  output logic       res_valid_o,
  output res_t       res_o
);

`include "decimal_string_to_int32_macros.svh"

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic              failed_q, failed_d;

  logic              term;
  logic [AccW-1:0]   acc_next;
  logic [AccW-1:0]   limit;
  logic              over;
  logic              err;

  // Terminator needs a free result slot; other bytes always pass
  assign term   = (ch_i == CH_TERM);
  assign take_o = valid_i && (!term || slot_free_i);

  // magnitude * 10 + digit as shift-add
  assign acc_next = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
                  + {{(AccW-4){1'b0}}, ch_i[3:0] - CH_ZERO[3:0]};
  assign limit    = neg_q ? NEG_LIMIT : POS_LIMIT;
  assign over     = acc_next > limit;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    failed_d = failed_q;
    if (take_o) begin
      if (term) begin
        phase_d  = PH_LEAD;
        neg_d    = 1'b0;
        mag_d    = '0;
        failed_d = 1'b0;
      end else if (!failed_q) begin
        unique case (phase_q)
          PH_SIGN: begin
            if (is_digit(ch_i)) begin
              if (over) begin
                failed_d = 1'b1;
              end else begin
                mag_d   = acc_next[MagW-1:0];
                phase_d = PH_DIGIT;
              end
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_DIGIT: begin
            if (is_digit(ch_i)) begin
              if (over) begin
                failed_d = 1'b1;
              end else begin
                mag_d = acc_next[MagW-1:0];
              end
            end else if (ch_i == CH_SPACE) begin
              phase_d = PH_TAIL;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_TAIL: begin
            phase_d = PH_TAIL;
          end
          PH_LEAD: begin
            if (is_space(ch_i)) begin
              phase_d = PH_LEAD;
            end else if ((ch_i == CH_MINUS) || (ch_i == CH_PLUS)) begin
              neg_d   = (ch_i == CH_MINUS);
              phase_d = PH_SIGN;
            end else if (is_digit(ch_i)) begin
              if (over) begin
                failed_d = 1'b1;
              end else begin
                mag_d   = acc_next[MagW-1:0];
                phase_d = PH_DIGIT;
              end
            end else begin
              failed_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Result on the terminator
  always_comb begin
    err         = failed_q || !((phase_q == PH_DIGIT) || (phase_q == PH_TAIL));
    res_valid_o = take_o && term;
    res_o.error = err;
    if (err) begin
      res_o.value = '0;
    end else if (neg_q) begin
      res_o.value = -$signed(mag_q);
    end else begin
      res_o.value = $signed(mag_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      failed_q <= failed_d;
    end
  end

  // Checks
  `DSI_ASSERT_NEXT(a_clear_after_term, take_o && term,
                   (phase_q == PH_LEAD) && !failed_q && !neg_q && (mag_q == '0))
  `DSI_ASSERT_NEXT(a_failed_sticky, failed_q && !(take_o && term), failed_q && $stable(mag_q))
  `DSI_ASSERT_NOW(a_mag_in_range, 1'b1, {4'b0000, mag_q} <= NEG_LIMIT)
  `DSI_ASSERT_NOW(a_error_zero_value, res_valid_o && res_o.error, res_o.value == '0)

endmodule

/* rtl/dsi_out_reg.sv */
// Result register: holds one result item until the receiver takes it.
module dsi_out_reg
  import dsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  res_t               res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               error_o
);

  logic valid_q;
  res_t res_q;

  // Slot frees up when empty or when its item is taken this cycle
  assign slot_free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = res_q.value;
  assign error_o     = res_q.error;

endmodule

/* rtl/decimal_string_to_int32.sv */
// Top level of the streaming decimal string to int32 converter.
//
// Input channel (in_valid_i/in_ready_o, ch_i): one ASCII byte per item.
// A zero byte ends the string; every other byte gives no result.
// Output channel (out_valid_o/out_ready_i, value_o, error_o): one item per
// string; value_o is the signed result, zero whenever error_o is set.
// Throughput: one byte per cycle, back to back, while no terminator waits
// for the result slot. The parse step (multiply by ten as a shift-add,
// compare with the int32 limit) sits between the input register and the
// parser state registers. The terminator of a string moves from the input
// register through the parse step into the result register once the
// result slot is free; the result then shows at the outputs.
// Reset clears the parser to the leading whitespace phase and empties both
// registers; no clearing pass is needed.
// When the receiver stalls, bytes other than the terminator keep flowing;
// a terminator waits in the input register until the result slot is free,
// and input ready then drops once that register holds it.
module decimal_string_to_int32
  import dsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               error_o
);

  logic       byte_valid;
  logic [7:0] byte_ch;
  logic       take;
  logic       slot_free;
  logic       res_valid;
  res_t       res;

  dsi_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .valid_o    (byte_valid),
    .ch_o       (byte_ch),
    .take_i     (take)
  );

  dsi_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_valid),
    .ch_i        (byte_ch),
    .take_o      (take),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dsi_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .error_o     (error_o)
  );

endmodule
